>>> rtl/core/tfe_pkg.sv
// ----------------------------------------------------------------------------
// tfe_pkg: shared types and constants of the telemetry frame encoder
// Holds the command passed from the front part to the back part, the byte
// kind codes and the configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package tfe_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Byte kind codes on the output tuser
    localparam logic [KIND_W-1:0] KIND_HEAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

    // Input opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST    = 2'd2;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] RST_HEADER = 8'hAB;
    localparam logic [BYTE_W-1:0] RST_SRC    = 8'h66;
    localparam logic [BYTE_W-1:0] RST_DST    = 8'hFE;

    // High byte of the 16-bit length field
    localparam logic [BYTE_W-1:0] LEN_HIGH = 8'h00;

    // One classified command: a frame start or one payload byte
    typedef struct packed {
        logic              is_start; // 1 start, 0 payload
        logic              close;    // append both checksums after this
        logic [BYTE_W-1:0] arg;      // func_id on start, data byte on payload
        logic [BYTE_W-1:0] len;      // payload length on start
    } t_cmd;

    // Head of the command queue as seen by the back part
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Configuration values used by the back part
    typedef struct packed {
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] src;
        logic [BYTE_W-1:0] dst;
    } t_cfg;

endpackage

>>> rtl/core/tfe_front.sv
// ----------------------------------------------------------------------------
// tfe_front: input classifier of the telemetry frame encoder
// Tracks the open frame and the remaining payload count, turns accepted
// items into commands for the queue and drops payload with no open frame.
// ----------------------------------------------------------------------------
module tfe_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_opcode,
    input  logic [tfe_pkg::BYTE_W-1:0]  i_func_id,
    input  logic [tfe_pkg::BYTE_W-1:0]  i_payload_len,
    input  logic [tfe_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                        o_push,
    output tfe_pkg::t_cmd               o_cmd
);

    logic                       r_open, n_open;
    logic [tfe_pkg::BYTE_W-1:0] r_left, n_left;
    logic                       last_byte;

    assign last_byte = (r_left == tfe_pkg::BYTE_W'(1));

    // Classify the item and update the frame state
    always_comb begin
        n_open = r_open;
        n_left = r_left;
        o_push = 1'b0;
        o_cmd  = '0;
        if (i_accept) begin
            if (i_opcode == tfe_pkg::OP_START) begin
                o_push         = 1'b1;
                o_cmd.is_start = 1'b1;
                o_cmd.close    = (i_payload_len == '0);
                o_cmd.arg      = i_func_id;
                o_cmd.len      = i_payload_len;
                n_open         = (i_payload_len != '0);
                n_left         = i_payload_len;
            end else if (r_open) begin
                o_push         = 1'b1;
                o_cmd.is_start = 1'b0;
                o_cmd.close    = last_byte;
                o_cmd.arg      = i_data_byte;
                o_cmd.len      = '0;
                n_left         = r_left - tfe_pkg::BYTE_W'(1);
                n_open         = !last_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

endmodule

>>> rtl/core/tfe_queue.sv
// ----------------------------------------------------------------------------
// tfe_queue: short command queue between front and back parts
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module tfe_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tfe_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output logic              o_ready,
    output tfe_pkg::t_q_head  o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tfe_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_ready     = (r_count != CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign do_push     = i_push && o_ready;
    assign do_pop      = i_pop && o_head.valid;

    // Advance pointers with explicit wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/tfe_back.sv
// ----------------------------------------------------------------------------
// tfe_back: byte serializer of the telemetry frame encoder
// Steps through each queued command one output byte per cycle unless stalled,
// keeps the running sum and the sum of sums, and drives the output register.
// ----------------------------------------------------------------------------
module tfe_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tfe_pkg::t_q_head            i_head,
    input  tfe_pkg::t_cfg               i_cfg,
    input  logic                        i_out_ready,
    output logic                        o_pop,
    output logic                        o_out_valid,
    output logic [tfe_pkg::BYTE_W-1:0]  o_out_byte,
    output logic [tfe_pkg::KIND_W-1:0]  o_out_kind,
    output logic                        o_out_end,
    output logic                        o_out_last
);

    // Byte positions within a command's output sequence
    localparam logic [2:0] STEP_HDR  = 3'd0;
    localparam logic [2:0] STEP_SRC  = 3'd1;
    localparam logic [2:0] STEP_DST  = 3'd2;
    localparam logic [2:0] STEP_FUNC = 3'd3;
    localparam logic [2:0] STEP_LENL = 3'd4;
    localparam logic [2:0] STEP_LENH = 3'd5;
    localparam logic [2:0] STEP_SUM  = 3'd6;
    localparam logic [2:0] STEP_ADD  = 3'd7;

    logic [2:0]                 r_step, n_step;
    logic [tfe_pkg::BYTE_W-1:0] r_sum, n_sum;
    logic [tfe_pkg::BYTE_W-1:0] r_add, n_add;
    logic                       r_valid;
    logic [tfe_pkg::BYTE_W-1:0] r_byte;
    logic [tfe_pkg::KIND_W-1:0] r_kind;
    logic                       r_end;
    logic                       r_last;

    logic                       advance, fire, is_last, framed, fresh;
    logic [tfe_pkg::BYTE_W-1:0] cur_byte;
    logic [tfe_pkg::KIND_W-1:0] cur_kind;
    logic [tfe_pkg::BYTE_W-1:0] sum_base, add_base;
    tfe_pkg::t_cmd              cmd;

    assign cmd     = i_head.cmd;
    assign advance = !r_valid || i_out_ready;
    assign fire    = advance && i_head.valid;

    // Select the byte at the current step
    always_comb begin
        cur_byte = r_sum;
        cur_kind = tfe_pkg::KIND_HEAD;
        unique case (r_step)
            STEP_HDR:  cur_byte = cmd.is_start ? i_cfg.header : cmd.arg;
            STEP_SRC:  cur_byte = i_cfg.src;
            STEP_DST:  cur_byte = i_cfg.dst;
            STEP_FUNC: cur_byte = cmd.arg;
            STEP_LENL: cur_byte = cmd.len;
            STEP_LENH: cur_byte = tfe_pkg::LEN_HIGH;
            STEP_SUM:  cur_byte = r_sum;
            STEP_ADD:  cur_byte = r_add;
            default:   cur_byte = r_sum;
        endcase
        if (r_step == STEP_SUM || r_step == STEP_ADD) begin
            cur_kind = tfe_pkg::KIND_CHECK;
        end else if (!cmd.is_start) begin
            cur_kind = tfe_pkg::KIND_DATA;
        end
    end

    // Find the last byte of this command and the step that follows
    always_comb begin
        if (cmd.close) begin
            is_last = (r_step == STEP_ADD);
        end else if (cmd.is_start) begin
            is_last = (r_step == STEP_LENH);
        end else begin
            is_last = (r_step == STEP_HDR);
        end
        if (is_last) begin
            n_step = STEP_HDR;
        end else if (!cmd.is_start && r_step == STEP_HDR) begin
            n_step = STEP_SUM;
        end else begin
            n_step = r_step + 3'd1;
        end
    end

    // Fold framed bytes into both sums; a start begins with fresh sums
    assign framed   = (r_step != STEP_SUM) && (r_step != STEP_ADD);
    assign fresh    = cmd.is_start && (r_step == STEP_HDR);
    assign sum_base = fresh ? '0 : r_sum;
    assign add_base = fresh ? '0 : r_add;
    assign n_sum    = sum_base + cur_byte;
    assign n_add    = add_base + n_sum;

    assign o_pop = fire && is_last;

    // Hold sequencer, sums and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_HDR;
            r_sum   <= '0;
            r_add   <= '0;
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_head.valid;
            if (i_head.valid) begin
                r_step <= n_step;
                if (framed) begin
                    r_sum <= n_sum;
                    r_add <= n_add;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= cur_byte;
            r_kind <= cur_kind;
            r_end  <= (r_step == STEP_ADD);
            r_last <= is_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_out_kind  = r_kind;
    assign o_out_end   = r_end;
    assign o_out_last  = r_last;

endmodule

>>> rtl/core/telemetry_frame_encoder_dual_checksum.sv
// ----------------------------------------------------------------------------
// telemetry_frame_encoder_dual_checksum: telemetry frame builder
// Serializes framed telemetry with an 8-bit sum and an 8-bit sum of sums.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: tuser is the opcode (0 start, 1 payload byte). A start carries
//     func_id and payload_len, a payload item carries data_byte.
//   m_axis: one frame byte per item; tuser gives the byte kind and the
//     frame end flag, tlast marks the last byte caused by one input item.
//   cfg: header, source and destination bytes, written while idle;
//     cfg_ready is always high, indexes beyond the register list are ignored.
// The first byte of an item passes through the command queue and then the
//   output register before it is presented on m_axis. Unless m_axis stalls,
//   the back serializer emits one byte per cycle, so a payload item gives
//   1 byte (3 when it closes the frame) and a start gives 6 bytes (8 for an
//   empty frame); payload streams at one byte per cycle.
// The command queue of QUEUE_DEPTH entries lets s_axis keep accepting while
//   m_axis is stalled; s_axis_tready drops only when the queue is full.
//   Payload with no open frame is accepted and dropped.
// Reset: synchronous, clears the open frame, the queue, the sums and the
//   output valid, and loads the configuration defaults.
// ----------------------------------------------------------------------------
module telemetry_frame_encoder_dual_checksum #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input item stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [23:0]                    i_s_axis_tdata, // func_id, payload_len, data_byte
    input  logic                           i_s_axis_tuser, // opcode
    // Output byte stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [7:0]                     o_m_axis_tdata, // out_byte
    output logic [2:0]                     o_m_axis_tuser, // byte_kind[1:0], frame_end
    output logic                           o_m_axis_tlast, // run_last
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tfe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    tfe_pkg::t_cfg    r_cfg;
    tfe_pkg::t_cmd    push_cmd;
    tfe_pkg::t_q_head q_head;
    logic             push, pop, q_ready, in_accept;
    logic [1:0]       out_kind;
    logic             out_end;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = q_ready;
    assign in_accept       = i_s_axis_tvalid && q_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header <= tfe_pkg::RST_HEADER;
            r_cfg.src    <= tfe_pkg::RST_SRC;
            r_cfg.dst    <= tfe_pkg::RST_DST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tfe_pkg::CFG_HEADER: r_cfg.header <= i_cfg_data;
                tfe_pkg::CFG_SRC:    r_cfg.src    <= i_cfg_data;
                tfe_pkg::CFG_DST:    r_cfg.dst    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tfe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_opcode      (i_s_axis_tuser),
        .i_func_id     (i_s_axis_tdata[7:0]),
        .i_payload_len (i_s_axis_tdata[15:8]),
        .i_data_byte   (i_s_axis_tdata[23:16]),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    tfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_head  (q_head)
    );

    tfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_cfg       (r_cfg),
        .i_out_ready (i_m_axis_tready),
        .o_pop       (pop),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_byte  (o_m_axis_tdata),
        .o_out_kind  (out_kind),
        .o_out_end   (out_end),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {out_end, out_kind};

endmodule

>>> rtl/core/tfe_checker.sv
// ----------------------------------------------------------------------------
// tfe_checker: port-level assertions for the telemetry frame encoder
// Watches the output stream and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module tfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [2:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // Hold a stalled output byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output byte dropped or changed while stalled");

    // Close a frame only on the last byte of an item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2] |-> o_m_axis_tlast)
        else $error("frame end without tlast");

    // Close a frame only on a checksum byte
    a_end_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2] |-> o_m_axis_tuser[1:0] == tfe_pkg::KIND_CHECK)
        else $error("frame end on a non-checksum byte");

    // Drop output valid after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind telemetry_frame_encoder_dual_checksum tfe_checker u_tfe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the telemetry frame encoder
// Streams frame starts and payload bytes into the encoder, predicts every
// output byte with its kind, frame end and run end flags, and compares the
// byte stream item by item. Configuration is changed between traffic phases,
// and both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    // Index past the register list; writes to it must have no effect
    localparam logic [tfe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // One predicted output item
    typedef struct packed {
        logic [7:0] val;
        logic [1:0] kind;
        logic       frame_end;
        logic       run_end;
    } t_frame_byte;

    // Predicts the byte stream and checks the observed one against it
    class frame_scoreboard;
        logic [7:0]  header_val;
        logic [7:0]  src_val;
        logic [7:0]  dst_val;
        logic        open;
        logic [7:0]  left;
        logic [7:0]  sum_run;
        logic [7:0]  sum_of_sums;
        t_frame_byte run_buf [8];
        int          run_len;
        t_frame_byte bytes_due [$];
        int          errors;

        function new();
            header_val  = tfe_pkg::RST_HEADER;
            src_val     = tfe_pkg::RST_SRC;
            dst_val     = tfe_pkg::RST_DST;
            open        = 1'b0;
            left        = 8'd0;
            sum_run     = 8'd0;
            sum_of_sums = 8'd0;
            errors      = 0;
        endfunction

        function void set_reg(logic [tfe_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                tfe_pkg::CFG_HEADER: header_val = val;
                tfe_pkg::CFG_SRC:    src_val    = val;
                tfe_pkg::CFG_DST:    dst_val    = val;
                default:    ;
            endcase
        endfunction

        // Append one byte that both checksums cover
        function void add_framed(logic [7:0] b, logic [1:0] kind);
            sum_run     = sum_run + b;
            sum_of_sums = sum_of_sums + sum_run;
            run_buf[run_len] = '{b, kind, 1'b0, 1'b0};
            run_len++;
        endfunction

        // Append both checksums and close the frame
        function void add_checks();
            run_buf[run_len]     = '{sum_run, tfe_pkg::KIND_CHECK, 1'b0, 1'b0};
            run_buf[run_len + 1] = '{sum_of_sums, tfe_pkg::KIND_CHECK, 1'b1, 1'b0};
            run_len += 2;
            open = 1'b0;
            left = 8'd0;
        endfunction

        function void note_item(logic op, logic [7:0] func, logic [7:0] len,
                                logic [7:0] data);
            run_len = 0;
            if (op == tfe_pkg::OP_START) begin
                sum_run     = 8'd0;
                sum_of_sums = 8'd0;
                open        = 1'b1;
                left        = len;
                add_framed(header_val, tfe_pkg::KIND_HEAD);
                add_framed(src_val, tfe_pkg::KIND_HEAD);
                add_framed(dst_val, tfe_pkg::KIND_HEAD);
                add_framed(func, tfe_pkg::KIND_HEAD);
                add_framed(len, tfe_pkg::KIND_HEAD);
                add_framed(tfe_pkg::LEN_HIGH, tfe_pkg::KIND_HEAD);
                if (len == 8'd0) add_checks();
            end else begin
                // drop a payload byte with no open frame
                if (!open) return;
                add_framed(data, tfe_pkg::KIND_DATA);
                left = left - 8'd1;
                if (left == 8'd0) add_checks();
            end
            run_buf[run_len - 1].run_end = 1'b1;
            for (int i = 0; i < run_len; i++) bytes_due.push_back(run_buf[i]);
        endfunction

        function void check_byte(logic [7:0] val, logic [1:0] kind, logic frame_end,
                                 logic run_end);
            t_frame_byte exp;
            if (bytes_due.size() == 0) begin
                $error("unexpected output item: out_byte %0h", val);
                errors++;
                return;
            end
            exp = bytes_due.pop_front();
            if (val !== exp.val) begin
                $error("out_byte mismatch: expected %0h, actual %0h", exp.val, val);
                errors++;
            end
            if (kind !== exp.kind) begin
                $error("byte_kind mismatch: expected %0d, actual %0d", exp.kind, kind);
                errors++;
            end
            if (frame_end !== exp.frame_end) begin
                $error("frame_end mismatch: expected %0b, actual %0b",
                       exp.frame_end, frame_end);
                errors++;
            end
            if (run_end !== exp.run_end) begin
                $error("run_last mismatch: expected %0b, actual %0b", exp.run_end, run_end);
                errors++;
            end
        endfunction

        function int pending();
            return bytes_due.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_axis_tvalid;
    logic                          o_s_axis_tready;
    logic [23:0]                   i_s_axis_tdata;
    logic                          i_s_axis_tuser;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready;
    logic [7:0]                    o_m_axis_tdata;
    logic [2:0]                    o_m_axis_tuser;
    logic                          o_m_axis_tlast;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [tfe_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]                    i_cfg_data;

    frame_scoreboard sb;
    bit              quiet;
    int              items_sent;

    telemetry_frame_encoder_dual_checksum dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the output side at random, except in the quiet stretch
    always @(posedge i_clk) begin
        i_m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);
    end

    // Watch all three channels and feed the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_reg(i_cfg_index, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_item(i_s_axis_tuser, i_s_axis_tdata[7:0],
                             i_s_axis_tdata[15:8], i_s_axis_tdata[23:16]);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_byte(o_m_axis_tdata, o_m_axis_tuser[1:0], o_m_axis_tuser[2],
                              o_m_axis_tlast);
            end
        end
    end

    // Hard limit on the run
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Present one input item and hold it until accepted
    task automatic send_item(input logic op, input logic [7:0] func, input logic [7:0] len,
                             input logic [7:0] data);
        while (!quiet && $urandom_range(99) < 22) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {data, len, func};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Start a frame and follow it with some payload bytes, random unused fields
    task automatic send_frame(input logic [7:0] len, input int n_bytes);
        send_item(tfe_pkg::OP_START, 8'($urandom), len, 8'($urandom));
        items_sent++;
        for (int i = 0; i < n_bytes; i++) begin
            send_item(tfe_pkg::OP_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
            items_sent++;
        end
    endtask

    // Write one configuration register
    task automatic cfg_write(input logic [tfe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_config(input logic [7:0] hdr, input logic [7:0] src,
                                input logic [7:0] dst);
        cfg_write(tfe_pkg::CFG_HEADER, hdr);
        cfg_write(tfe_pkg::CFG_SRC, src);
        cfg_write(tfe_pkg::CFG_DST, dst);
        cfg_write(CFG_SPARE, 8'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Release the input side and let every expected byte come out
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Mostly complete frames, some cut short, some stray items
    task automatic random_traffic(input int target);
        int   r;
        int   len;
        int   cut;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_item(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (r < 20) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(255, 128)
                                               : $urandom_range(16, 1);
                cut = $urandom_range((len - 1 < 6) ? len - 1 : 6);
                send_frame(8'(len), cut);
            end else begin
                len = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
                send_frame(8'(len), len);
            end
        end
    endtask

    // Main sequence
    initial begin
        sb = new();
        quiet = 1'b0;
        items_sent = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= tfe_pkg::OP_START;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= tfe_pkg::CFG_HEADER;
        i_cfg_data      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: stray payload, empty frame, wraps and abandoned frames
        send_item(tfe_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'hFF);
        send_item(tfe_pkg::OP_PAYLOAD, 8'hFF, 8'hFF, 8'h00);
        send_item(tfe_pkg::OP_START,   8'hFF, 8'h00, 8'hFF);
        send_item(tfe_pkg::OP_START,   8'h00, 8'h01, 8'h00);
        send_item(tfe_pkg::OP_PAYLOAD, 8'hFF, 8'hFF, 8'hFF);
        send_item(tfe_pkg::OP_START,   8'h5A, 8'h02, 8'h00);
        send_item(tfe_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'h80);
        send_item(tfe_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'h7F);
        send_item(tfe_pkg::OP_PAYLOAD, 8'h12, 8'h34, 8'h33);
        send_item(tfe_pkg::OP_START,   8'hC3, 8'hFF, 8'hFF);
        send_item(tfe_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'h01);
        send_item(tfe_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'hFE);
        send_item(tfe_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'h55);
        send_item(tfe_pkg::OP_START,   8'h3C, 8'h00, 8'h00);
        send_item(tfe_pkg::OP_START,   8'h81, 8'h80, 8'h00);
        send_item(tfe_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'hAA);
        send_item(tfe_pkg::OP_START,   8'h7E, 8'h03, 8'h00);
        send_item(tfe_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'hFF);
        send_item(tfe_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'hFF);
        send_item(tfe_pkg::OP_PAYLOAD, 8'h00, 8'h00, 8'hFF);
        send_item(tfe_pkg::OP_START,   8'hE7, 8'h01, 8'hFF);
        send_item(tfe_pkg::OP_PAYLOAD, 8'hFF, 8'hFF, 8'h00);
        items_sent = 22;
        drain();

        // All-zero configuration
        apply_config(8'h00, 8'h00, 8'h00);
        random_traffic(items_sent + 60);
        drain();

        // All-ones configuration, one frame of the longest length
        apply_config(8'hFF, 8'hFF, 8'hFF);
        send_frame(8'hFF, 255);
        random_traffic(items_sent + 20);
        drain();

        // Random configuration, no stalls on either side
        apply_config(8'($urandom), 8'($urandom), 8'($urandom));
        quiet = 1'b1;
        random_traffic(items_sent + 60);
        drain();
        quiet = 1'b0;

        // Random configuration again, stalls back on
        apply_config(8'($urandom), 8'($urandom), 8'($urandom));
        random_traffic(items_sent + 40);
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/tfe_pkg.sv
rtl/core/tfe_front.sv
rtl/core/tfe_queue.sv
rtl/core/tfe_back.sv
rtl/core/telemetry_frame_encoder_dual_checksum.sv
rtl/core/tfe_checker.sv
tb/tb_top.sv
